/* hw/rtl/fwpk_pkg.sv */
// ----------------------------------------------------------------------------
// fwpk_pkg: shared types and constants of the firmware frame packer
// Frame geometry, CRC-32 constants, the front-to-back command record and the
// bitwise reflected CRC-32 byte update.
// ----------------------------------------------------------------------------
package fwpk_pkg;

    localparam int FRAME_PAYLOAD = 64;                       // 4 .. 128
    localparam int POS_W         = $clog2(FRAME_PAYLOAD + 1);
    localparam int QDEPTH        = 2;                        // command queue depth
    localparam int QPTR_W        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    localparam logic [31:0] CRC_POLY_REFL = 32'hEDB8_8320;   // 0x04C11DB7 reflected
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

    // One classified image byte, as handed from the front to the back.
    typedef struct packed {
        logic        hdr;        // frame opens: frame number goes first
        logic [31:0] hdr_num;
        logic [7:0]  data;
        logic        chk;        // frame closes after this byte
        logic [31:0] chk_val;    // negated byte sum
        logic        ends;       // checksum closes the image
        logic [31:0] crc;        // inverted image CRC
        logic        extra;      // trailing empty frame follows
        logic [31:0] extra_num;
    } t_cmd;

    // Reflected CRC-32 update by one byte, one bit per step.
    function automatic logic [31:0] fwpk_crc_byte(input logic [31:0] crc,
                                                  input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'h0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/fwpk_front.sv */
// ----------------------------------------------------------------------------
// fwpk_front: input classifier
// Tracks frame number, payload position, negated sum and CRC; turns every
// accepted byte into one command for the back end.
// ----------------------------------------------------------------------------
module fwpk_front
    import fwpk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_image_byte,
    input  logic        i_is_last,
    output t_cmd        o_cmd
);

    logic [31:0]      r_frame_count;
    logic [POS_W-1:0] r_pos;
    logic [31:0]      r_neg_sum;     // 0 - running byte sum
    logic [31:0]      r_crc;

    logic [31:0]      n_frame_count;
    logic [POS_W-1:0] n_pos;
    logic [31:0]      n_neg_sum;
    logic [31:0]      n_crc;
    logic             full;
    logic             hdr;

    always_comb begin
        hdr           = (r_pos == '0);
        n_frame_count = r_frame_count + {31'h0, hdr};
        n_pos         = r_pos + POS_W'(1);
        n_neg_sum     = r_neg_sum - {24'h0, i_image_byte};
        n_crc         = fwpk_crc_byte(r_crc, i_image_byte);
        full          = (n_pos == POS_W'(FRAME_PAYLOAD));

        o_cmd.hdr       = hdr;
        o_cmd.hdr_num   = r_frame_count;
        o_cmd.data      = i_image_byte;
        o_cmd.chk       = full | i_is_last;
        o_cmd.chk_val   = n_neg_sum;
        o_cmd.ends      = i_is_last & ~full;
        o_cmd.crc       = ~n_crc;
        o_cmd.extra     = full & i_is_last;
        o_cmd.extra_num = n_frame_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_pos         <= '0;
            r_neg_sum     <= '0;
            r_crc         <= CRC_INIT;
        end else if (i_accept) begin
            if (i_is_last) begin
                r_frame_count <= '0;
                r_pos         <= '0;
                r_neg_sum     <= '0;
                r_crc         <= CRC_INIT;
            end else if (full) begin
                r_frame_count <= n_frame_count;
                r_pos         <= '0;
                r_neg_sum     <= '0;
                r_crc         <= n_crc;
            end else begin
                r_frame_count <= n_frame_count;
                r_pos         <= n_pos;
                r_neg_sum     <= n_neg_sum;
                r_crc         <= n_crc;
            end
        end
    end

endmodule

/* hw/rtl/fwpk_queue.sv */
// ----------------------------------------------------------------------------
// fwpk_queue: command queue
// Short register FIFO between the classifier and the serializer.
// ----------------------------------------------------------------------------
module fwpk_queue
    import fwpk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wr_cmd,
    output logic o_full,
    input  logic i_rd,
    output t_cmd o_rd_cmd,
    output logic o_valid
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_full   = (r_count == QCNT_W'(QDEPTH));
    assign o_valid  = (r_count != '0);
    assign o_rd_cmd = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_rd) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/fwpk_back.sv */
// ----------------------------------------------------------------------------
// fwpk_back: byte serializer
// Walks each command through its header, data, checksum and trailing-frame
// bytes into the output register, one byte per cycle while it is empty or popped.
// ----------------------------------------------------------------------------
module fwpk_back
    import fwpk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cmd_valid,
    output logic        o_cmd_pop,
    input  logic        i_pop,
    output logic        o_out_valid,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end,
    output logic        o_image_end,
    output logic [31:0] o_image_crc
);

    typedef enum logic [4:0] {
        S_HDR0, S_HDR1, S_HDR2, S_HDR3,
        S_DATA,
        S_CHK0, S_CHK1, S_CHK2, S_CHK3,
        S_XHDR0, S_XHDR1, S_XHDR2, S_XHDR3,
        S_XCHK0, S_XCHK1, S_XCHK2, S_XCHK3
    } t_step;

    t_step       r_step;
    logic        r_mid;        // head command partly sent
    logic        r_out_valid;
    logic [7:0]  r_frame_byte;
    logic        r_frame_end;
    logic        r_image_end;
    logic [31:0] r_image_crc;

    t_step       cur;
    t_step       nxt;
    logic        done;
    logic        load;
    logic [7:0]  byte_sel;
    logic        fe;
    logic        ie;

    assign load = i_cmd_valid & (~r_out_valid | i_pop);

    always_comb begin
        cur      = r_mid ? r_step : (i_cmd.hdr ? S_HDR0 : S_DATA);
        nxt      = cur;
        done     = 1'b0;
        byte_sel = 8'h00;
        fe       = 1'b0;
        ie       = 1'b0;
        case (cur)
            S_HDR0:  begin byte_sel = i_cmd.hdr_num[31:24]; nxt = S_HDR1; end
            S_HDR1:  begin byte_sel = i_cmd.hdr_num[23:16]; nxt = S_HDR2; end
            S_HDR2:  begin byte_sel = i_cmd.hdr_num[15:8];  nxt = S_HDR3; end
            S_HDR3:  begin byte_sel = i_cmd.hdr_num[7:0];   nxt = S_DATA; end
            S_DATA: begin
                byte_sel = i_cmd.data;
                nxt      = S_CHK0;
                done     = ~i_cmd.chk;
            end
            S_CHK0:  begin byte_sel = i_cmd.chk_val[7:0];   nxt = S_CHK1; end
            S_CHK1:  begin byte_sel = i_cmd.chk_val[15:8];  nxt = S_CHK2; end
            S_CHK2:  begin byte_sel = i_cmd.chk_val[23:16]; nxt = S_CHK3; end
            S_CHK3: begin
                byte_sel = i_cmd.chk_val[31:24];
                fe       = 1'b1;
                ie       = i_cmd.ends;
                nxt      = S_XHDR0;
                done     = ~i_cmd.extra;
            end
            S_XHDR0: begin byte_sel = i_cmd.extra_num[31:24]; nxt = S_XHDR1; end
            S_XHDR1: begin byte_sel = i_cmd.extra_num[23:16]; nxt = S_XHDR2; end
            S_XHDR2: begin byte_sel = i_cmd.extra_num[15:8];  nxt = S_XHDR3; end
            S_XHDR3: begin byte_sel = i_cmd.extra_num[7:0];   nxt = S_XCHK0; end
            S_XCHK0: nxt = S_XCHK1;
            S_XCHK1: nxt = S_XCHK2;
            S_XCHK2: nxt = S_XCHK3;
            S_XCHK3: begin
                fe   = 1'b1;
                ie   = 1'b1;
                done = 1'b1;
            end
            default: done = 1'b1;
        endcase
    end

    assign o_cmd_pop = load & done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_HDR0;
            r_mid       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid  <= 1'b1;
            r_frame_byte <= byte_sel;
            r_frame_end  <= fe;
            r_image_end  <= ie;
            r_image_crc  <= ie ? i_cmd.crc : 32'h0;
            r_mid        <= ~done;
            r_step       <= nxt;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_frame_byte;
    assign o_frame_end  = r_frame_end;
    assign o_image_end  = r_image_end;
    assign o_image_crc  = r_image_crc;

endmodule

/* hw/rtl/firmware_frame_packer_crc.sv */
// ----------------------------------------------------------------------------
// firmware_frame_packer_crc: firmware image framer with image CRC-32
// Cuts an image byte stream into numbered, checksummed frames and reports
// the inverted reflected CRC-32 of the image on the final stream byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: an item (one image byte plus the
//   last-byte mark) is taken on a clock edge with push high and full low.
//   Output side is a queue read port: the oldest stream byte sits on the
//   o_ ports while empty is low and leaves on an edge with pop high.
//   Each frame: 4-byte frame number (big-endian), up to FRAME_PAYLOAD image
//   bytes, 4-byte negated byte sum (little-endian). An image ending on a
//   full frame gets one extra empty frame (number plus zero checksum).
//   Path: the first byte of an item is written into the command queue,
//   then loaded into the output register, from which it is popped.
//   Throughput: the classifier takes one item per cycle while the queue
//   has room; the serializer emits one stream byte per cycle while pop
//   drains the output. An item yields 1 to 13 stream bytes: 1 for a
//   mid-frame byte, 5 when it opens a frame, 4 or 12 more when it closes
//   one. The serializer output sets the sustained rate, about 1.13 stream
//   bytes per item at 64-byte frames. With pop low the output register
//   holds, the 2-entry command queue fills, full rises; nothing is dropped.
//   Reset (synchronous, active low) clears frame number, position, sum,
//   CRC, the queue and the output valid flag; an image's last byte does the
//   same to the framing state, so the next image starts at frame zero.
// ----------------------------------------------------------------------------
module firmware_frame_packer_crc
    import fwpk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_image_byte,
    input  logic        i_is_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end,
    output logic        o_image_end,
    output logic [31:0] o_image_crc
);

    t_cmd front_cmd;     // classified item from the front
    t_cmd head_cmd;      // oldest queued command
    logic accept;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic out_valid;

    // an item goes in whenever the command queue has room
    assign accept = push & ~q_full;
    assign full   = q_full;

    fwpk_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_image_byte (i_image_byte),
        .i_is_last    (i_is_last),
        .o_cmd        (front_cmd)
    );

    fwpk_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (accept),
        .i_wr_cmd (front_cmd),
        .o_full   (q_full),
        .i_rd     (q_pop),
        .o_rd_cmd (head_cmd),
        .o_valid  (q_valid)
    );

    // serializer pops the head as its last byte is loaded
    fwpk_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (head_cmd),
        .i_cmd_valid  (q_valid),
        .o_cmd_pop    (q_pop),
        .i_pop        (pop),
        .o_out_valid  (out_valid),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end),
        .o_image_end  (o_image_end),
        .o_image_crc  (o_image_crc)
    );

    assign empty = ~out_valid;

endmodule
